/* design/ptsd_pkg.sv */
// ----------------------------------------------------------------------------
// Point-to-segment distance package
// Widths, types and codes shared by the front end, the cells and the top level.
// ----------------------------------------------------------------------------
package ptsd_pkg;

  localparam int COORD_W = 16;
  localparam int DIFF_W  = COORD_W + 1;
  localparam int PROD_W  = 2 * DIFF_W;
  localparam int SUM_W   = PROD_W + 1;
  localparam int QUO_W   = SUM_W;
  localparam int NUM_W   = 2 * SUM_W;
  localparam int HALF_W  = (SUM_W + 1) / 2;
  localparam int HIGH_W  = SUM_W - HALF_W;
  localparam int ROOT_W  = (QUO_W + 1) / 2;
  localparam int RAD_W   = 2 * ROOT_W;
  localparam int REM_W   = ROOT_W + 2;
  localparam int DIST_W  = 17;

  typedef logic signed [COORD_W-1:0] coord_t;

  typedef enum logic [1:0] {
    PART_START    = 2'd0,
    PART_END      = 2'd1,
    PART_INTERIOR = 2'd2
  } part_t;

  typedef struct packed {
    logic  valid;
    part_t part;
  } ctl_t;

endpackage

/* design/point_to_segment_distance.sv */
// ----------------------------------------------------------------------------
// Point-to-segment distance
// Distance from a point to a 2-D segment in fixed point with 4 fractional bits.
//
//   Channel   Handshake        Payload
//   query     start / busy     point_x, point_y, start_x, start_y, end_x, end_y
//   result    done (strobe)    distance, nearest_part
//
// One transaction is taken in every cycle; busy is always low.
// Each result passes the front-end registers, the restoring divider chain of QUO_W
// cells, the square-root chain of ROOT_W cells and the output register.
// Reset clears the valid bits of every stage; no clearing pass is needed.
// The receiver cannot stall, and results leave one per cycle in query order.
// ----------------------------------------------------------------------------
module point_to_segment_distance (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  output logic                         busy,
  input  ptsd_pkg::coord_t             point_x,
  input  ptsd_pkg::coord_t             point_y,
  input  ptsd_pkg::coord_t             start_x,
  input  ptsd_pkg::coord_t             start_y,
  input  ptsd_pkg::coord_t             end_x,
  input  ptsd_pkg::coord_t             end_y,
  output logic                         done,
  output logic [ptsd_pkg::DIST_W-1:0]  distance,
  output logic [1:0]                   nearest_part
);
  import ptsd_pkg::*;

  ctl_t              dctl  [0:QUO_W];
  logic [SUM_W-1:0]  drem  [0:QUO_W];
  logic [QUO_W-1:0]  dlow  [0:QUO_W];
  logic [SUM_W-1:0]  ddiv  [0:QUO_W];
  ctl_t              sctl  [0:ROOT_W];
  logic [RAD_W-1:0]  srad  [0:ROOT_W];
  logic [REM_W-1:0]  srem  [0:ROOT_W];
  logic [ROOT_W-1:0] sroot [0:ROOT_W];

  assign busy = 1'b0;

  ptsd_front u_front (
    .clk(clk), .rst(rst), .start(start),
    .point_x(point_x), .point_y(point_y),
    .start_x(start_x), .start_y(start_y),
    .end_x(end_x), .end_y(end_y),
    .ctl_o(dctl[0]), .rem_o(drem[0]), .low_o(dlow[0]), .div_o(ddiv[0])
  );

  for (genvar i = 0; i < QUO_W; i++) begin : g_div
    ptsd_div_cell u_cell (
      .clk(clk), .rst(rst),
      .ctl_i(dctl[i]), .rem_i(drem[i]), .low_i(dlow[i]), .div_i(ddiv[i]),
      .ctl_o(dctl[i+1]), .rem_o(drem[i+1]), .low_o(dlow[i+1]), .div_o(ddiv[i+1])
    );
  end

  assign sctl[0]  = dctl[QUO_W];
  assign srad[0]  = RAD_W'(dlow[QUO_W]);
  assign srem[0]  = '0;
  assign sroot[0] = '0;

  for (genvar j = 0; j < ROOT_W; j++) begin : g_sqrt
    ptsd_sqrt_cell u_cell (
      .clk(clk), .rst(rst),
      .ctl_i(sctl[j]), .rad_i(srad[j]), .rem_i(srem[j]), .root_i(sroot[j]),
      .ctl_o(sctl[j+1]), .rad_o(srad[j+1]), .rem_o(srem[j+1]), .root_o(sroot[j+1])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= sctl[ROOT_W].valid;
    end
    distance     <= DIST_W'(sroot[ROOT_W]);
    nearest_part <= sctl[ROOT_W].part;
  end

  assert property (@(posedge clk) disable iff (rst)
    (sctl[ROOT_W].valid && !rst) |=> done)
    else $error("Finished transaction was not presented.");
  assert property (@(posedge clk) disable iff (rst)
    (done && nearest_part == PART_START) |-> (distance <= DIST_W'(92682)))
    else $error("Start-endpoint distance out of range.");

endmodule

/* design/ptsd_front.sv */
// ----------------------------------------------------------------------------
// Point-to-segment distance front end
// Forms differences, products and sums, picks the region and builds the
// dividend and divisor that enter the divider chain.
// ----------------------------------------------------------------------------
module ptsd_front (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  ptsd_pkg::coord_t            point_x,
  input  ptsd_pkg::coord_t            point_y,
  input  ptsd_pkg::coord_t            start_x,
  input  ptsd_pkg::coord_t            start_y,
  input  ptsd_pkg::coord_t            end_x,
  input  ptsd_pkg::coord_t            end_y,
  output ptsd_pkg::ctl_t              ctl_o,
  output logic [ptsd_pkg::SUM_W-1:0]  rem_o,
  output logic [ptsd_pkg::QUO_W-1:0]  low_o,
  output logic [ptsd_pkg::SUM_W-1:0]  div_o
);
  import ptsd_pkg::*;

  logic v1, v2, v3, v4;
  logic signed [DIFF_W-1:0] dx, dy, vx, vy, wx, wy;
  logic signed [PROD_W-1:0] p_dxvx, p_dyvy, p_dxdx, p_dydy, p_dxvy, p_dyvx;
  logic signed [PROD_W-1:0] p_vxvx, p_vyvy, p_wxwx, p_wywy;
  logic signed [SUM_W-1:0]  t3, len3, c3, sqa3, sqb3;
  logic signed [SUM_W-1:0]  cmag;
  part_t                    part3, part4;
  logic [SUM_W-1:0]         sq4, div4;
  logic [2*HIGH_W-1:0]      hh;
  logic [SUM_W-1:0]         hl;
  logic [2*HALF_W-1:0]      ll;
  logic [NUM_W-1:0]         num;

  always_comb begin
    if (t3 <= 0) begin
      part3 = PART_START;
    end else if (t3 >= len3) begin
      part3 = PART_END;
    end else begin
      part3 = PART_INTERIOR;
    end
    cmag = (c3 < 0) ? -c3 : c3;
    if (part4 == PART_INTERIOR) begin
      num = (NUM_W'(hh) << (2 * HALF_W)) + (NUM_W'(hl) << (HALF_W + 1)) + NUM_W'(ll);
    end else begin
      num = NUM_W'(sq4);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      ctl_o.valid <= 1'b0;
    end else begin
      v1 <= start;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
      ctl_o.valid <= v4;
    end
    dx <= DIFF_W'(end_x) - DIFF_W'(start_x);
    dy <= DIFF_W'(end_y) - DIFF_W'(start_y);
    vx <= DIFF_W'(point_x) - DIFF_W'(start_x);
    vy <= DIFF_W'(point_y) - DIFF_W'(start_y);
    wx <= DIFF_W'(point_x) - DIFF_W'(end_x);
    wy <= DIFF_W'(point_y) - DIFF_W'(end_y);
    p_dxvx <= dx * vx;
    p_dyvy <= dy * vy;
    p_dxdx <= dx * dx;
    p_dydy <= dy * dy;
    p_dxvy <= dx * vy;
    p_dyvx <= dy * vx;
    p_vxvx <= vx * vx;
    p_vyvy <= vy * vy;
    p_wxwx <= wx * wx;
    p_wywy <= wy * wy;
    t3   <= SUM_W'(p_dxvx) + SUM_W'(p_dyvy);
    len3 <= SUM_W'(p_dxdx) + SUM_W'(p_dydy);
    c3   <= SUM_W'(p_dxvy) - SUM_W'(p_dyvx);
    sqa3 <= SUM_W'(p_vxvx) + SUM_W'(p_vyvy);
    sqb3 <= SUM_W'(p_wxwx) + SUM_W'(p_wywy);
    part4 <= part3;
    sq4   <= (part3 == PART_END) ? sqb3 : sqa3;
    div4  <= (part3 == PART_INTERIOR) ? len3 : SUM_W'(1);
    hh    <= cmag[SUM_W-1:HALF_W] * cmag[SUM_W-1:HALF_W];
    hl    <= SUM_W'(cmag[SUM_W-1:HALF_W] * cmag[HALF_W-1:0]);
    ll    <= cmag[HALF_W-1:0] * cmag[HALF_W-1:0];
    ctl_o.part <= part4;
    rem_o <= num[NUM_W-1:QUO_W];
    low_o <= num[QUO_W-1:0];
    div_o <= div4;
  end

  assert property (@(posedge clk) disable iff (rst) (start && !rst) |=> v1)
    else $error("Accepted transaction did not enter the front end.");
  assert property (@(posedge clk) disable iff (rst)
    ctl_o.valid |-> (rem_o < div_o))
    else $error("Dividend head not below divisor.");

endmodule

/* design/ptsd_div_cell.sv */
// ----------------------------------------------------------------------------
// Point-to-segment distance divider cell
// One restoring step: produces one quotient bit and hands on the remainder.
// ----------------------------------------------------------------------------
module ptsd_div_cell (
  input  logic                        clk,
  input  logic                        rst,
  input  ptsd_pkg::ctl_t              ctl_i,
  input  logic [ptsd_pkg::SUM_W-1:0]  rem_i,
  input  logic [ptsd_pkg::QUO_W-1:0]  low_i,
  input  logic [ptsd_pkg::SUM_W-1:0]  div_i,
  output ptsd_pkg::ctl_t              ctl_o,
  output logic [ptsd_pkg::SUM_W-1:0]  rem_o,
  output logic [ptsd_pkg::QUO_W-1:0]  low_o,
  output logic [ptsd_pkg::SUM_W-1:0]  div_o
);
  import ptsd_pkg::*;

  logic [SUM_W:0] sh, diff;
  logic           ge;

  always_comb begin
    sh   = {rem_i, low_i[QUO_W-1]};
    diff = sh - {1'b0, div_i};
    ge   = (sh >= {1'b0, div_i});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_o.valid <= 1'b0;
    end else begin
      ctl_o.valid <= ctl_i.valid;
    end
    ctl_o.part <= ctl_i.part;
    rem_o <= ge ? diff[SUM_W-1:0] : sh[SUM_W-1:0];
    low_o <= {low_i[QUO_W-2:0], ge};
    div_o <= div_i;
  end

  assert property (@(posedge clk) disable iff (rst) ctl_o.valid |-> (rem_o < div_o))
    else $error("Divider remainder not below divisor.");

endmodule

/* design/ptsd_sqrt_cell.sv */
// ----------------------------------------------------------------------------
// Point-to-segment distance square-root cell
// One digit step of the integer square root: two radicand bits in, one root bit out.
// ----------------------------------------------------------------------------
module ptsd_sqrt_cell (
  input  logic                         clk,
  input  logic                         rst,
  input  ptsd_pkg::ctl_t               ctl_i,
  input  logic [ptsd_pkg::RAD_W-1:0]   rad_i,
  input  logic [ptsd_pkg::REM_W-1:0]   rem_i,
  input  logic [ptsd_pkg::ROOT_W-1:0]  root_i,
  output ptsd_pkg::ctl_t               ctl_o,
  output logic [ptsd_pkg::RAD_W-1:0]   rad_o,
  output logic [ptsd_pkg::REM_W-1:0]   rem_o,
  output logic [ptsd_pkg::ROOT_W-1:0]  root_o
);
  import ptsd_pkg::*;

  logic [REM_W+1:0] rem2, trial, diff;
  logic             ge;

  always_comb begin
    rem2  = {rem_i, rad_i[RAD_W-1:RAD_W-2]};
    trial = (REM_W + 2)'({root_i, 2'b01});
    diff  = rem2 - trial;
    ge    = (rem2 >= trial);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_o.valid <= 1'b0;
    end else begin
      ctl_o.valid <= ctl_i.valid;
    end
    ctl_o.part <= ctl_i.part;
    rad_o  <= rad_i << 2;
    rem_o  <= ge ? diff[REM_W-1:0] : rem2[REM_W-1:0];
    root_o <= {root_i[ROOT_W-2:0], ge};
  end

  assert property (@(posedge clk) disable iff (rst)
    ctl_o.valid |-> (rem_o <= REM_W'({root_o, 1'b0})))
    else $error("Square-root remainder exceeds twice the root.");

endmodule

/* dv/point_to_segment_distance_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Point-to-segment distance testbench
// Sends directed and random queries with random idle cycles, takes the expected
// distance and nearest part of each one from its table row or a prediction, and checks every result in order.
// ----------------------------------------------------------------------------
module point_to_segment_distance_tb;
  import ptsd_pkg::*;

  typedef struct {
    logic [DIST_W-1:0] length;
    part_t             part;
  } answer_t;

  typedef struct {
    coord_t            px, py, ax, ay, bx, by;
    bit                typed;
    logic [DIST_W-1:0] length;
    part_t             part;
  } query_row_t;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES   = 80;
  localparam int RANDOM_ITEMS   = 600;

  logic              clk, rst, start, busy, done;
  coord_t            point_x, point_y, start_x, start_y, end_x, end_y;
  logic [DIST_W-1:0] distance;
  logic [1:0]        nearest_part;

  bit                row_typed;
  answer_t           row_answer;
  answer_t           pending_answers[$];
  int                error_count;
  int                quiet_cycles;

  query_row_t directed_rows[] = '{
    '{16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 1'b1, 17'd0, PART_START},
    '{16'sd16, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 1'b1, 17'd16, PART_START},
    '{16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd32, 16'sd0, 1'b1, 17'd0, PART_START},
    '{16'sd32, 16'sd0, 16'sd0, 16'sd0, 16'sd32, 16'sd0, 1'b1, 17'd0, PART_END},
    '{16'sd16, 16'sd48, 16'sd0, 16'sd0, 16'sd32, 16'sd0, 1'b1, 17'd48, PART_INTERIOR},
    '{-16'sd48, 16'sd0, 16'sd0, 16'sd0, 16'sd32, 16'sd0, 1'b1, 17'd48, PART_START},
    '{16'sd80, 16'sd0, 16'sd0, 16'sd0, 16'sd32, 16'sd0, 1'b1, 17'd48, PART_END},
    '{16'sd0, 16'sd64, 16'sd0, 16'sd0, 16'sd0, 16'sd64, 1'b1, 17'd0, PART_END},
    '{16'sd32767, 16'sd32767, -16'sd32768, -16'sd32768, -16'sd32768, -16'sd32768,
      1'b0, 17'd0, PART_START},
    '{-16'sd32768, -16'sd32768, 16'sd32767, 16'sd32767, 16'sd32767, 16'sd32767,
      1'b0, 17'd0, PART_START},
    '{16'sd32767, -16'sd32768, -16'sd32768, -16'sd32768, 16'sd32767, 16'sd32767,
      1'b0, 17'd0, PART_START},
    '{-16'sd32768, 16'sd32767, -16'sd32768, -16'sd32768, 16'sd32767, 16'sd32767,
      1'b0, 17'd0, PART_START},
    '{16'sd32767, 16'sd32767, -16'sd32768, 16'sd32767, 16'sd32767, -16'sd32768,
      1'b0, 17'd0, PART_START},
    '{16'sd0, 16'sd0, -16'sd32768, 16'sd0, 16'sd32767, 16'sd0, 1'b1, 17'd0,
      PART_INTERIOR},
    '{16'sd0, 16'sd32767, -16'sd32768, -16'sd32768, 16'sd32767, -16'sd32768,
      1'b0, 17'd0, PART_START},
    '{16'sd5, -16'sd7, 16'sd1, 16'sd3, -16'sd9, 16'sd2, 1'b0, 17'd0, PART_START},
    '{-16'sd1, -16'sd1, 16'sd1, 16'sd1, 16'sd0, 16'sd0, 1'b0, 17'd0, PART_START}
  };

  point_to_segment_distance DUT (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .point_x(point_x), .point_y(point_y), .start_x(start_x), .start_y(start_y),
    .end_x(end_x), .end_y(end_y),
    .done(done), .distance(distance), .nearest_part(nearest_part)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic [32:0] floor_root(input logic [63:0] n);
    logic [32:0]  r;
    logic [32:0]  cand;
    logic [127:0] sq;
    r = '0;
    for (int b = 32; b >= 0; b--) begin
      cand = r | (33'd1 << b);
      sq   = 128'(cand) * 128'(cand);
      if (sq <= 128'(n)) r = cand;
    end
    return r;
  endfunction

  function automatic answer_t nearest_distance(input coord_t px, py, ax, ay, bx, by);
    longint       dx, dy, vx, vy, wx, wy, t, len2, c;
    logic [127:0] cc, lhs;
    logic [63:0]  cmag, d, cand;
    answer_t      a;
    dx = longint'(bx) - longint'(ax);
    dy = longint'(by) - longint'(ay);
    vx = longint'(px) - longint'(ax);
    vy = longint'(py) - longint'(ay);
    t    = dx * vx + dy * vy;
    len2 = dx * dx + dy * dy;
    if (t <= 0) begin
      a.length = DIST_W'(floor_root(64'(vx * vx + vy * vy)));
      a.part   = PART_START;
    end else if (t >= len2) begin
      wx = longint'(px) - longint'(bx);
      wy = longint'(py) - longint'(by);
      a.length = DIST_W'(floor_root(64'(wx * wx + wy * wy)));
      a.part   = PART_END;
    end else begin
      c    = dx * vy - dy * vx;
      cmag = (c < 0) ? 64'(-c) : 64'(c);
      cc   = 128'(cmag) * 128'(cmag);
      d    = '0;
      for (int b = 31; b >= 0; b--) begin
        cand = d | (64'd1 << b);
        lhs  = 128'(cand) * 128'(cand) * 128'(len2);
        if (lhs <= cc) d = cand;
      end
      a.length = DIST_W'(d);
      a.part   = PART_INTERIOR;
    end
    return a;
  endfunction

  always @(posedge clk) begin
    answer_t exp_a;
    if (rst) begin
      quiet_cycles <= 0;
    end else begin
      if (done) begin
        if (pending_answers.size() == 0) begin
          $error("result with no transaction outstanding: distance %0d part %0d",
                 distance, nearest_part);
          error_count++;
        end else begin
          exp_a = pending_answers.pop_front();
          if (distance !== exp_a.length) begin
            $error("distance: expected %0d, actual %0d", exp_a.length, distance);
            error_count++;
          end
          if (nearest_part !== exp_a.part) begin
            $error("nearest_part: expected %0d, actual %0d", exp_a.part, nearest_part);
            error_count++;
          end
        end
      end
      if (start && !busy) begin
        if (row_typed) pending_answers.push_back(row_answer);
        else pending_answers.push_back(nearest_distance(point_x, point_y, start_x,
                                                        start_y, end_x, end_y));
      end
      if (done || (start && !busy)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("FAILED: results differ");
        $finish;
      end
    end
  end

  task automatic send_query(input coord_t px, py, ax, ay, bx, by, input bit typed,
                            input answer_t a);
    @(negedge clk);
    start      <= 1'b1;
    point_x    <= px;
    point_y    <= py;
    start_x    <= ax;
    start_y    <= ay;
    end_x      <= bx;
    end_y      <= by;
    row_typed  <= typed;
    row_answer <= a;
    do @(posedge clk); while (busy);
  endtask

  task automatic idle_cycle();
    @(negedge clk);
    start <= 1'b0;
    @(posedge clk);
  endtask

  function automatic coord_t pick_coord(input int mode);
    case (mode)
      0: return coord_t'($urandom);
      1: return coord_t'($urandom_range(0, 511)) - 16'sd256;
      default: return ($urandom_range(0, 1) != 0) ? 16'sh7FFF : 16'sh8000;
    endcase
  endfunction

  initial begin
    answer_t none;
    coord_t  px, py, ax, ay, bx, by;
    int      mode;
    none = '{length: '0, part: PART_START};
    error_count = 0;
    rst = 1'b1;
    start = 1'b0;
    row_typed = 1'b0;
    row_answer = none;
    {point_x, point_y, start_x, start_y, end_x, end_y} = '0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    foreach (directed_rows[i]) begin
      send_query(directed_rows[i].px, directed_rows[i].py, directed_rows[i].ax,
                 directed_rows[i].ay, directed_rows[i].bx, directed_rows[i].by,
                 directed_rows[i].typed,
                 '{length: directed_rows[i].length, part: directed_rows[i].part});
    end

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n == 300) begin
        idle_cycle();
        while (pending_answers.size() != 0) @(posedge clk);
      end
      if ((n < 150 || n >= 300) && $urandom_range(0, 99) < 13) idle_cycle();
      mode = $urandom_range(0, 9);
      px = pick_coord(mode < 5 ? 0 : (mode < 9 ? 1 : 2));
      py = pick_coord(mode < 5 ? 0 : (mode < 9 ? 1 : 2));
      ax = pick_coord(mode < 5 ? 0 : (mode < 9 ? 1 : 2));
      ay = pick_coord(mode < 5 ? 0 : (mode < 9 ? 1 : 2));
      bx = pick_coord(mode < 5 ? 0 : (mode < 9 ? 1 : 2));
      by = pick_coord(mode < 5 ? 0 : (mode < 9 ? 1 : 2));
      if ($urandom_range(0, 15) == 0) begin
        bx = ax;
        by = ay;
      end
      send_query(px, py, ax, ay, bx, by, 1'b0, none);
    end

    idle_cycle();
    while (pending_answers.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
